>>> hw/rtl/rmq_pkg.sv
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int FIFO_DEPTH_DEF = 4;
    localparam int RAD_W = 32;
    localparam int DIFF_W = 17;
    localparam int Q_BITS = 15;
    localparam int SAT_MAX = 32767;

    localparam logic [1:0] SLOT_W = 2'd0;
    localparam logic [1:0] SLOT_X = 2'd1;
    localparam logic [1:0] SLOT_Y = 2'd2;
    localparam logic [1:0] SLOT_Z = 2'd3;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [15:0] q_w;
        logic signed [15:0] q_x;
        logic signed [15:0] q_y;
        logic signed [15:0] q_z;
    } quat_t;

    typedef struct packed {
        logic [RAD_W-1:0]         rad;
        logic [1:0]               dom;
        logic signed [DIFF_W-1:0] d_w;
        logic signed [DIFF_W-1:0] d_x;
        logic signed [DIFF_W-1:0] d_y;
        logic signed [DIFF_W-1:0] d_z;
    } cls_t;

endpackage

>>> hw/rtl/rmq_front.sv
module rmq_front import rmq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  mat_t s_data,
    output logic f_valid,
    input  logic f_ready,
    output cls_t f_data
);

    localparam int XW = RAD_W + 1;

    logic        vld_reg;
    cls_t        cls_reg;
    cls_t        cls_next;
    logic signed [XW-1:0] e00, e11, e22, one, trace, rad_s, mii;
    logic signed [DIFF_W-1:0] a01, a02, a10, a12, a20, a21;
    logic        pos, gt10, gt2;

    assign e00 = XW'(s_data.m00);
    assign e11 = XW'(s_data.m11);
    assign e22 = XW'(s_data.m22);
    assign one = XW'(1) << FRAC_BITS;
    assign a01 = DIFF_W'(s_data.m01);
    assign a02 = DIFF_W'(s_data.m02);
    assign a10 = DIFF_W'(s_data.m10);
    assign a12 = DIFF_W'(s_data.m12);
    assign a20 = DIFF_W'(s_data.m20);
    assign a21 = DIFF_W'(s_data.m21);

    assign trace = e00 + e11 + e22;
    assign pos = trace > 0;
    assign gt10 = e11 > e00;
    assign mii = gt10 ? e11 : e00;
    assign gt2 = e22 > mii;

    always_comb begin
        cls_next.dom = SLOT_W;
        cls_next.d_w = a21 - a12;
        cls_next.d_x = a21 - a12;
        cls_next.d_y = a02 - a20;
        cls_next.d_z = a10 - a01;
        rad_s = trace + one;
        if (!pos) begin
            if (gt2) begin
                cls_next.dom = SLOT_Z;
                rad_s = e22 - (e11 + e00) + one;
                cls_next.d_x = a20 + a02;
                cls_next.d_y = a21 + a12;
                cls_next.d_w = a10 - a01;
            end else if (gt10) begin
                cls_next.dom = SLOT_Y;
                rad_s = e11 - (e00 + e22) + one;
                cls_next.d_z = a12 + a21;
                cls_next.d_x = a10 + a01;
                cls_next.d_w = a02 - a20;
            end else begin
                cls_next.dom = SLOT_X;
                rad_s = e00 - (e22 + e11) + one;
                cls_next.d_y = a01 + a10;
                cls_next.d_z = a02 + a20;
                cls_next.d_w = a21 - a12;
            end
        end
        cls_next.rad = rad_s[XW-1] ? '0 : rad_s[RAD_W-1:0];
    end

    assign s_ready = !vld_reg || f_ready;
    assign f_valid = vld_reg;
    assign f_data = cls_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            cls_reg <= cls_next;
        end
    end

endmodule

>>> hw/rtl/rmq_fifo.sv
module rmq_fifo import rmq_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cls_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output cls_t out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cls_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;
    logic          push, pop;

    assign in_ready = cnt_reg != CW'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_reg] <= in_data;
        end
    end

endmodule

>>> hw/rtl/rmq_back.sv
module rmq_back import rmq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  cls_t  in_data,
    output logic  m_valid,
    input  logic  m_ready,
    output quat_t m_data
);

    localparam int RW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int SW = RW + FRAC_BITS;
    localparam int RTW = (SW + 1) / 2;
    localparam int TW = 2 * RTW + 1;
    localparam int NW = DIFF_W + FRAC_BITS;
    localparam int DW = (NW > RTW + 16) ? NW : RTW + 16;
    localparam int HW = (RTW + 1 > 17) ? RTW + 1 : 17;

    logic adv;

    // square root, one result bit per stage
    logic [TW-1:0]  sq_rem [0:RTW];
    logic [RTW-1:0] sq_res [0:RTW];
    cls_t           sq_cls [0:RTW];
    logic           sq_vld [0:RTW];

    // lane division
    logic [DW-1:0]  dv_rem  [0:Q_BITS][0:3];
    logic [Q_BITS-1:0] dv_q [0:Q_BITS][0:3];
    logic [3:0]     dv_ovf  [0:Q_BITS];
    logic [3:0]     dv_neg  [0:Q_BITS];
    logic [RTW-1:0] dv_root [0:Q_BITS];
    logic [1:0]     dv_dom  [0:Q_BITS];
    logic [15:0]    dv_half [0:Q_BITS];
    logic           dv_vld  [0:Q_BITS];

    logic           m_valid_reg;
    quat_t          m_data_reg;
    quat_t          m_data_next;

    logic [RTW-1:0] root;
    logic signed [DIFF_W-1:0] pd [4];
    logic [DIFF_W-1:0] pmag [4];
    logic [DW-1:0]  pnum [4];
    logic [3:0]     povf, pneg;
    logic [HW-1:0]  phx;
    logic [15:0]    phalf;
    logic signed [15:0] lane_out [4];

    assign adv = !m_valid_reg || m_ready;
    assign in_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld[0] <= 1'b0;
        end else if (adv) begin
            sq_vld[0] <= in_valid;
        end
        if (adv) begin
            sq_rem[0] <= TW'(in_data.rad[RW-1:0]) << FRAC_BITS;
            sq_res[0] <= '0;
            sq_cls[0] <= in_data;
        end
    end

    for (genvar g = 0; g < RTW; g++) begin : g_sq
        localparam int B = RTW - 1 - g;
        logic [TW-1:0] t;
        assign t = (TW'(sq_res[g]) << (B + 1)) | (TW'(1) << (2 * B));
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld[g+1] <= 1'b0;
            end else if (adv) begin
                sq_vld[g+1] <= sq_vld[g];
            end
            if (adv) begin
                sq_cls[g+1] <= sq_cls[g];
                if (sq_rem[g] >= t) begin
                    sq_rem[g+1] <= sq_rem[g] - t;
                    sq_res[g+1] <= sq_res[g] | (RTW'(1) << B);
                end else begin
                    sq_rem[g+1] <= sq_rem[g];
                    sq_res[g+1] <= sq_res[g];
                end
            end
        end
    end

    assign root = sq_res[RTW];
    assign pd[0] = sq_cls[RTW].d_w;
    assign pd[1] = sq_cls[RTW].d_x;
    assign pd[2] = sq_cls[RTW].d_y;
    assign pd[3] = sq_cls[RTW].d_z;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            pneg[l] = pd[l][DIFF_W-1];
            pmag[l] = pneg[l] ? DIFF_W'(-pd[l]) : DIFF_W'(pd[l]);
            pnum[l] = (DW'(pmag[l]) << (FRAC_BITS - 1)) + DW'(root >> 1);
            povf[l] = pnum[l] >= (DW'(root) << Q_BITS);
        end
        phx = (HW'(root) + HW'(1)) >> 1;
        phalf = (phx > HW'(SAT_MAX)) ? 16'(SAT_MAX) : phx[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld[0] <= 1'b0;
        end else if (adv) begin
            dv_vld[0] <= sq_vld[RTW];
        end
        if (adv) begin
            for (int l = 0; l < 4; l++) begin
                dv_rem[0][l] <= pnum[l];
                dv_q[0][l] <= '0;
            end
            dv_ovf[0] <= povf;
            dv_neg[0] <= pneg;
            dv_root[0] <= root;
            dv_dom[0] <= sq_cls[RTW].dom;
            dv_half[0] <= phalf;
        end
    end

    // restoring division, one quotient bit per stage in each lane
    for (genvar s = 0; s < Q_BITS; s++) begin : g_dv
        localparam int B = Q_BITS - 1 - s;
        logic [DW-1:0] sub;
        assign sub = DW'(dv_root[s]) << B;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld[s+1] <= 1'b0;
            end else if (adv) begin
                dv_vld[s+1] <= dv_vld[s];
            end
            if (adv) begin
                for (int l = 0; l < 4; l++) begin
                    if (dv_rem[s][l] >= sub) begin
                        dv_rem[s+1][l] <= dv_rem[s][l] - sub;
                        dv_q[s+1][l] <= dv_q[s][l] | (Q_BITS'(1) << B);
                    end else begin
                        dv_rem[s+1][l] <= dv_rem[s][l];
                        dv_q[s+1][l] <= dv_q[s][l];
                    end
                end
                dv_ovf[s+1] <= dv_ovf[s];
                dv_neg[s+1] <= dv_neg[s];
                dv_root[s+1] <= dv_root[s];
                dv_dom[s+1] <= dv_dom[s];
                dv_half[s+1] <= dv_half[s];
            end
        end
    end

    always_comb begin
        logic signed [15:0] qq;
        for (int l = 0; l < 4; l++) begin
            qq = signed'({1'b0, dv_q[Q_BITS][l]});
            if (dv_root[Q_BITS] == '0) begin
                lane_out[l] = '0;
            end else if (dv_dom[Q_BITS] == 2'(l)) begin
                lane_out[l] = signed'(dv_half[Q_BITS]);
            end else if (dv_ovf[Q_BITS][l]) begin
                lane_out[l] = dv_neg[Q_BITS][l] ? 16'sh8000 : 16'sh7fff;
            end else begin
                lane_out[l] = dv_neg[Q_BITS][l] ? -qq : qq;
            end
        end
        m_data_next.q_w = lane_out[SLOT_W];
        m_data_next.q_x = lane_out[SLOT_X];
        m_data_next.q_y = lane_out[SLOT_Y];
        m_data_next.q_z = lane_out[SLOT_Z];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_vld[Q_BITS];
        end
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

>>> hw/rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion (Shepperd's method), all values signed Q2.14 with
// FRAC_BITS fraction bits, outputs saturated. Fully pipelined: one item per cycle
// when the result side keeps up. The back end has a square root of R stages, where
// R = ceil((max(FRAC_BITS,17) + 2 + FRAC_BITS) / 2) (one root bit per stage), and a
// divider of depth 15 (one quotient bit per stage). The front classifies each item
// into a small queue, so input can keep flowing briefly while the output stalls.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  mat_t  s_data,
    output logic  m_valid,
    input  logic  m_ready,
    output quat_t m_data
);

    logic f_valid, f_ready, q_valid, q_ready;
    cls_t f_data, q_data;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .f_valid(f_valid), .f_ready(f_ready), .f_data(f_data)
    );

    rmq_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

`ifndef NO_ASSERTIONS
    a_rst_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid && !f_valid)
        else $error("output or front valid after reset");
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> f_valid && !f_ready)
        else $error("input stalled with room in the queue");
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> f_valid)
        else $error("accepted item lost in front stage");
`endif

endmodule
